/* hw/rtl/flha_pkg.sv */
// Package: shared constants and types for the free-list heap allocator.
`default_nettype none
package flha_pkg;

    localparam int HEAP_UNITS     = 4096;
    localparam int UNIT_BYTES     = 16;
    localparam int GROW_MIN_UNITS = 1024;
    localparam int WALK_LIMIT     = 4 * HEAP_UNITS + 16;

    localparam int IDX_W   = $clog2(HEAP_UNITS);
    localparam int NEED_W  = IDX_W + 1;
    localparam int STEP_W  = $clog2(WALK_LIMIT + 2);
    localparam int UNIT_SH = $clog2(UNIT_BYTES);
    localparam int HDR_W   = 2 * IDX_W;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] byte_count;
        logic [11:0] release_unit;
    } req_t;

    typedef struct packed {
        logic [11:0] granted_unit;
        logic        done_ok;
    } rsp_t;

    typedef struct packed {
        logic [IDX_W-1:0] nxt;
        logic [IDX_W-1:0] size;
    } hdr_t;

endpackage
`default_nettype wire

/* hw/rtl/flha_hdr_ram.sv */
// Generic single-write, single-read synchronous RAM for block headers.
`default_nettype none
module flha_hdr_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/free_list_heap_allocator.sv */
// Top level: next-fit free-list heap allocator over a header RAM.
`default_nettype none
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: func selects
//   allocate (byte_count) or release (release_unit, payload unit index).
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one item per
//   request: granted_unit (0 = null) and done_ok.
// Flow: one item at a time. Every header access is one read of the
//   header RAM (registered read port), so the walk advances one free
//   block per cycle. An allocate that finds no fit grows the heap, runs
//   the full release sequence on the new block and then walks again.
//   The first item after reset also passes through S_INIT to build the
//   sentinel.
// Reset: rover = 0, break = 1, list not built; header RAM is not cleared,
//   the sentinel at unit 0 is written by the first item.
// Stall: the result sits in an output register; a new item is accepted
//   while it waits, but the block holds its next result until the
//   receiver takes the previous one.
module free_list_heap_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire flha_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output flha_pkg::rsp_t     rsp
);
    import flha_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_A_ROV   = 4'd3;
    localparam logic [3:0] S_A_PREV  = 4'd4;
    localparam logic [3:0] S_A_CHK   = 4'd5;
    localparam logic [3:0] S_A_SPLIT = 4'd6;
    localparam logic [3:0] S_L_START = 4'd7;
    localparam logic [3:0] S_L_WALK  = 4'd8;
    localparam logic [3:0] S_L_RDBP  = 4'd9;
    localparam logic [3:0] S_L_RDNX  = 4'd10;
    localparam logic [3:0] S_L_WRP   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    localparam logic [NEED_W-1:0] GROW_MIN = NEED_W'(GROW_MIN_UNITS);
    localparam logic [NEED_W:0]   TOP_LIM  = (NEED_W+1)'(HEAP_UNITS - 1);
    localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(WALK_LIMIT);

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  rover_reg, rover_next;
    logic              list_ready_reg, list_ready_next;
    logic [NEED_W-1:0] break_reg, break_next;
    logic              func_reg, func_next;
    logic [IDX_W-1:0]  rel_reg, rel_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    hdr_t              prev_hdr_reg, prev_hdr_next;
    hdr_t              hp_reg, hp_next;
    hdr_t              hb_reg, hb_next;
    logic [IDX_W-1:0]  bp_reg, bp_next;
    logic [IDX_W-1:0]  nx_reg, nx_next;
    logic [IDX_W-1:0]  bsize_reg, bsize_next;
    logic [IDX_W-1:0]  bnext_reg, bnext_next;
    logic              from_grow_reg, from_grow_next;
    logic [STEP_W-1:0] asteps_reg, asteps_next;
    logic [STEP_W-1:0] lsteps_reg, lsteps_next;
    logic [IDX_W-1:0]  grant_reg, grant_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;

    // header RAM port signals
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    hdr_t             ram_wdata;
    logic [HDR_W-1:0] ram_rdata;
    hdr_t             rd;

    flha_hdr_ram #(
        .DEPTH(HEAP_UNITS),
        .WIDTH(HDR_W)
    ) u_hdr_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd        = hdr_t'(ram_rdata);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // allocate arithmetic
    logic [NEED_W-1:0] need_calc;
    logic [NEED_W-1:0] grow_units;
    logic [NEED_W:0]   grow_top;
    logic [IDX_W-1:0]  split_size;
    // link arithmetic
    logic              walk_in, walk_brk;
    logic [NEED_W-1:0] bp_end, p_end;

    always_comb
    begin
        need_calc  = NEED_W'((17'(req.byte_count) + 17'(UNIT_BYTES - 1)) >> UNIT_SH) + 1'b1;
        grow_units = (need_reg < GROW_MIN) ? GROW_MIN : need_reg;
        grow_top   = {1'b0, break_reg} + {1'b0, grow_units};
        split_size = rd.size - need_reg[IDX_W-1:0];
        walk_in    = (bp_reg > p_reg) && (bp_reg < rd.nxt);
        walk_brk   = (p_reg >= rd.nxt) && ((bp_reg > p_reg) || (bp_reg < rd.nxt));
        bp_end     = {1'b0, bp_reg} + {1'b0, hb_reg.size};
        p_end      = {1'b0, p_reg} + {1'b0, hp_reg.size};
    end

    always_comb
    begin
        state_next      = state_reg;
        rover_next      = rover_reg;
        list_ready_next = list_ready_reg;
        break_next      = break_reg;
        func_next       = func_reg;
        rel_next        = rel_reg;
        need_next       = need_reg;
        p_next          = p_reg;
        prev_next       = prev_reg;
        prev_hdr_next   = prev_hdr_reg;
        hp_next         = hp_reg;
        hb_next         = hb_reg;
        bp_next         = bp_reg;
        nx_next         = nx_reg;
        bsize_next      = bsize_reg;
        bnext_next      = bnext_reg;
        from_grow_next  = from_grow_reg;
        asteps_next     = asteps_reg;
        lsteps_next     = lsteps_reg;
        grant_next      = grant_reg;
        ok_next         = ok_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    rel_next   = req.release_unit;
                    need_next  = need_calc;
                    state_next = list_ready_reg ? S_DISP : S_INIT;
                end
            end
            S_INIT:
            begin
                // sentinel at unit 0 points to itself, size zero
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = '0;
                rover_next      = '0;
                list_ready_next = 1'b1;
                state_next      = S_DISP;
            end
            S_DISP:
            begin
                grant_next     = '0;
                ok_next        = 1'b0;
                from_grow_next = 1'b0;
                asteps_next    = '0;
                if (func_reg == FUNC_ALLOC)
                begin
                    state_next = S_A_ROV;
                end
                else if (rel_reg != '0)
                begin
                    bp_next    = rel_reg - 1'b1;
                    state_next = S_L_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_A_ROV:
            begin
                ram_re     = 1'b1;
                ram_raddr  = rover_reg;
                prev_next  = rover_reg;
                state_next = S_A_PREV;
            end
            S_A_PREV:
            begin
                prev_hdr_next = rd;
                p_next        = rd.nxt;
                ram_re        = 1'b1;
                ram_raddr     = rd.nxt;
                state_next    = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (asteps_reg > STEP_LIM)
                begin
                    state_next = S_DONE;
                end
                else if ({1'b0, rd.size} >= need_reg)
                begin
                    rover_next = prev_reg;
                    if ({1'b0, rd.size} == need_reg)
                    begin
                        // exact fit: unlink p
                        ram_we     = 1'b1;
                        ram_waddr  = prev_reg;
                        ram_wdata  = '{nxt: rd.nxt, size: prev_hdr_reg.size};
                        grant_next = p_reg + 1'b1;
                        ok_next    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // split from the tail; fetch the tail header
                        ram_we     = 1'b1;
                        ram_waddr  = p_reg;
                        ram_wdata  = '{nxt: rd.nxt, size: split_size};
                        ram_re     = 1'b1;
                        ram_raddr  = p_reg + split_size;
                        p_next     = p_reg + split_size;
                        state_next = S_A_SPLIT;
                    end
                end
                else if (p_reg == rover_reg)
                begin
                    if (grow_top > TOP_LIM)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = break_reg[IDX_W-1:0];
                        ram_wdata      = '{nxt: '0, size: grow_units[IDX_W-1:0]};
                        bp_next        = break_reg[IDX_W-1:0];
                        break_next     = grow_top[NEED_W-1:0];
                        from_grow_next = 1'b1;
                        state_next     = S_L_START;
                    end
                end
                else
                begin
                    prev_next     = p_reg;
                    prev_hdr_next = rd;
                    p_next        = rd.nxt;
                    ram_re        = 1'b1;
                    ram_raddr     = rd.nxt;
                    asteps_next   = asteps_reg + 1'b1;
                end
            end
            S_A_SPLIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = '{nxt: rd.nxt, size: need_reg[IDX_W-1:0]};
                grant_next = p_reg + 1'b1;
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_L_START:
            begin
                ram_re      = 1'b1;
                ram_raddr   = rover_reg;
                p_next      = rover_reg;
                lsteps_next = '0;
                state_next  = S_L_WALK;
            end
            S_L_WALK:
            begin
                if (walk_in || walk_brk)
                begin
                    hp_next    = rd;
                    nx_next    = rd.nxt;
                    ram_re     = 1'b1;
                    ram_raddr  = bp_reg;
                    state_next = S_L_RDBP;
                end
                else if (lsteps_reg >= STEP_LIM)
                begin
                    // walk limit: give up, answer null / not ok
                    grant_next = '0;
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    p_next      = rd.nxt;
                    ram_re      = 1'b1;
                    ram_raddr   = rd.nxt;
                    lsteps_next = lsteps_reg + 1'b1;
                end
            end
            S_L_RDBP:
            begin
                hb_next    = rd;
                ram_re     = 1'b1;
                ram_raddr  = nx_reg;
                state_next = S_L_RDNX;
            end
            S_L_RDNX:
            begin
                // merge with upper neighbor when adjacent
                if (bp_end == {1'b0, nx_reg})
                begin
                    bsize_next = hb_reg.size + rd.size;
                    bnext_next = rd.nxt;
                    ram_wdata  = '{nxt: rd.nxt, size: hb_reg.size + rd.size};
                end
                else
                begin
                    bsize_next = hb_reg.size;
                    bnext_next = nx_reg;
                    ram_wdata  = '{nxt: nx_reg, size: hb_reg.size};
                end
                ram_we     = 1'b1;
                ram_waddr  = bp_reg;
                state_next = S_L_WRP;
            end
            S_L_WRP:
            begin
                // merge with lower neighbor when adjacent
                ram_we    = 1'b1;
                ram_waddr = p_reg;
                if (p_end == {1'b0, bp_reg})
                begin
                    ram_wdata = '{nxt: bnext_reg, size: hp_reg.size + bsize_reg};
                end
                else
                begin
                    ram_wdata = '{nxt: bp_reg, size: hp_reg.size};
                end
                rover_next = p_reg;
                if (from_grow_reg)
                begin
                    from_grow_next = 1'b0;
                    asteps_next    = asteps_reg + 1'b1;
                    state_next     = S_A_ROV;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{granted_unit: grant_reg, done_ok: ok_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rover_reg      <= '0;
            list_ready_reg <= 1'b0;
            break_reg      <= NEED_W'(1);
            from_grow_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rover_reg      <= rover_next;
            list_ready_reg <= list_ready_next;
            break_reg      <= break_next;
            from_grow_reg  <= from_grow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        rel_reg      <= rel_next;
        need_reg     <= need_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        prev_hdr_reg <= prev_hdr_next;
        hp_reg       <= hp_next;
        hb_reg       <= hb_next;
        bp_reg       <= bp_next;
        nx_reg       <= nx_next;
        bsize_reg    <= bsize_next;
        bnext_reg    <= bnext_next;
        asteps_reg   <= asteps_next;
        lsteps_reg   <= lsteps_next;
        grant_reg    <= grant_next;
        ok_reg       <= ok_next;
        out_reg      <= out_next;
    end

    // no read and write to the same header in one cycle
    a_no_rw_alias: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && (ram_waddr == ram_raddr)))
        else $error("header read and write collide");

    // break pointer never passes the last usable unit
    a_break_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, break_reg} <= TOP_LIM)
        else $error("break pointer beyond arena");

    // once the list is built it stays built
    a_list_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(list_ready_reg))
        else $error("list_ready dropped");

    // an accepted item leaves idle on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item not started");

    // a result is only loaded when the output slot is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result overwritten");
endmodule
`default_nettype wire

/* verif/free_list_heap_allocator_test.sv */
// Testbench for the free-list heap allocator: predicted results, random traffic, stalls.
`timescale 1ns / 1ps

class heap_scoreboard;
    localparam int unsigned H  = flha_pkg::HEAP_UNITS;
    localparam int unsigned WL = flha_pkg::WALK_LIMIT;

    int unsigned nxt_q[H];
    int unsigned size_q[H];
    int unsigned rover;
    bit          built;
    int unsigned brk;

    flha_pkg::rsp_t pending_rsp[$];
    logic [11:0]    live_blocks[$];
    int             errors;

    function new();
        rover  = 0;
        built  = 0;
        brk    = 1;
        errors = 0;
    endfunction

    function bit link_block(int unsigned bp_in);
        int unsigned p;
        int unsigned bp;
        int unsigned nx;
        int unsigned steps;
        p = rover % H;
        bp = bp_in % H;
        steps = 0;
        while (!(bp > p && bp < nxt_q[p])) begin
            if (p >= nxt_q[p] && (bp > p || bp < nxt_q[p]))
                break;
            p = nxt_q[p] % H;
            steps++;
            if (steps > WL)
                return 0;
        end
        nx = nxt_q[p] % H;
        if (bp + size_q[bp] == nx) begin
            size_q[bp] = (size_q[bp] + size_q[nx]) % H;
            nxt_q[bp]  = nxt_q[nx] % H;
        end else begin
            nxt_q[bp] = nx;
        end
        if (p + size_q[p] == bp) begin
            size_q[p] = (size_q[p] + size_q[bp]) % H;
            nxt_q[p]  = nxt_q[bp] % H;
        end else begin
            nxt_q[p] = bp;
        end
        rover = p;
        return 1;
    endfunction

    function bit grow_arena(int unsigned need);
        int unsigned nu;
        int unsigned up;
        nu = (need < flha_pkg::GROW_MIN_UNITS) ? flha_pkg::GROW_MIN_UNITS : need;
        if (brk + nu > H - 1)
            return 0;
        up = brk;
        brk += nu;
        size_q[up] = nu % H;
        return link_block(up);
    endfunction

    function int unsigned carve(int unsigned bytes);
        int unsigned need;
        int unsigned prev;
        int unsigned p;
        need = (bytes + flha_pkg::UNIT_BYTES - 1) / flha_pkg::UNIT_BYTES + 1;
        prev = rover % H;
        p = nxt_q[prev] % H;
        for (int unsigned steps = 0; steps <= WL; steps++) begin
            if (size_q[p] >= need) begin
                if (size_q[p] == need) begin
                    nxt_q[prev] = nxt_q[p] % H;
                end else begin
                    size_q[p] -= need;
                    p = (p + size_q[p]) % H;
                    size_q[p] = need % H;
                end
                rover = prev;
                return p + 1;
            end
            if (p == rover) begin
                if (!grow_arena(need))
                    return 0;
                p = rover % H;
            end
            prev = p;
            p = nxt_q[p] % H;
        end
        return 0;
    endfunction

    // Called on each accepted request item.
    function void note(flha_pkg::req_t r);
        flha_pkg::rsp_t e;
        int unsigned g;
        e = '0;
        if (!built) begin
            nxt_q[0]  = 0;
            size_q[0] = 0;
            rover = 0;
            built = 1;
        end
        if (r.func == flha_pkg::FUNC_ALLOC) begin
            g = carve(32'(r.byte_count));
            e.granted_unit = g[11:0];
            e.done_ok = (g != 0);
            if (g != 0)
                live_blocks.push_back(g[11:0]);
        end else if (r.release_unit != 0) begin
            e.done_ok = link_block(r.release_unit - 1);
        end
        pending_rsp.push_back(e);
    endfunction

    function void check(flha_pkg::rsp_t got);
        flha_pkg::rsp_t e;
        if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item: %h", got);
            return;
        end
        e = pending_rsp.pop_front();
        if (got.granted_unit !== e.granted_unit || got.done_ok !== e.done_ok) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected unit %0d ok %0d, got unit %0d ok %0d",
                         e.granted_unit, e.done_ok, got.granted_unit, got.done_ok);
        end
    endfunction
endclass

module free_list_heap_allocator_test;
    import flha_pkg::*;

    localparam int IDLE_LIMIT = 60000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    heap_scoreboard sb = new();
    int idle_cycles = 0;
    int burst_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;

    free_list_heap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Receiver: the stall pattern is redrawn at random, periodically, from always ready
    // through even stalling to mostly stalled.
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result monitor and watchdog share the edge; outputs are sampled pre-update.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check(rsp);
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Drives one item and returns after it is accepted; the gap before it,
    // if any, comes from the burst pattern.
    task automatic send(req_t r);
        if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!(req_valid && req_ready));
        sb.note(r);
    endtask

    task automatic alloc_item(int unsigned bytes);
        req_t r;
        r = '0;
        r.func = FUNC_ALLOC;
        r.byte_count = bytes[15:0];
        r.release_unit = 12'($urandom_range(0, 4095));
        send(r);
    endtask

    // Releases a live block picked at random, or the null unit when asked or when none is live.
    task automatic release_item(bit null_unit);
        req_t r;
        int idx;
        r = '0;
        r.func = FUNC_RELEASE;
        r.byte_count = 16'($urandom_range(0, 65535));
        if (!null_unit && sb.live_blocks.size() > 0) begin
            idx = $urandom_range(0, sb.live_blocks.size() - 1);
            r.release_unit = sb.live_blocks[idx];
            sb.live_blocks.delete(idx);
        end
        send(r);
    endtask

    initial begin
        int unsigned pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first request is a null release, then size edges,
        // free-and-reuse, an oversize request and growth up to the arena top.
        release_item(1'b1);
        alloc_item(0);
        alloc_item(1);
        alloc_item(16);
        alloc_item(17);
        release_item(1'b0);
        alloc_item(17);
        alloc_item(65535);
        repeat (4) alloc_item(16368);
        alloc_item(16384);
        alloc_item(1);
        while (sb.live_blocks.size() > 0)
            release_item(1'b0);
        alloc_item(32);
        release_item(1'b1);

        // Random traffic, mostly small blocks with valid frees.
        for (int i = 0; i < 550; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                release_item(1'b1);
            end else if (pick < ((sb.live_blocks.size() > 60) ? 63 : 33)) begin
                release_item(1'b0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    alloc_item($urandom_range(0, 255));
                else if (pick < 92)
                    alloc_item($urandom_range(256, 4000));
                else if (pick < 97)
                    alloc_item($urandom_range(4001, 20000));
                else
                    alloc_item($urandom_range(0, 65535));
            end
        end

        req_valid <= 1'b0;
        while (sb.pending_rsp.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
